// ===== design/bracket_frame_crc16_checker_defines.svh =====
// Assertion macros shared by the checker of the bracket frame CRC checker.
`ifndef BRACKET_FRAME_CRC16_CHECKER_DEFINES_SVH
`define BRACKET_FRAME_CRC16_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define BFCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define BFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bfcc_pkg.sv =====
// Shared types, constants and byte functions of the bracket frame CRC checker.
`timescale 1ns / 1ps
`default_nettype none
package bfcc_pkg;

  localparam int CONTENT_LIMIT_DEF = 99;
  localparam int LINE_LIMIT_DEF    = 127;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    ST_FORWARD  = 3'd0,
    ST_NO_START = 3'd1,
    ST_NO_END   = 3'd2,
    ST_CRC_BAD  = 3'd3,
    ST_BAD_LEN  = 3'd4
  } status_t;

  typedef struct packed {
    logic take;
    logic clear_line;
    logic post_status;
    logic emit_start;
    logic emit_run;
  } dp_cmd_t;

  typedef struct packed {
    status_t status;
    logic    out_free;
    logic    emit_done;
  } dp_stat_t;

  // One byte of reflected CRC-16/Modbus, bit at a time.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Upper-case ASCII digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = {4'h3, n};
    end else begin
      r = {4'h0, n} + 8'h37;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/bfcc_ctrl.sv =====
// Line controller: accepts bytes, evaluates the line, and sequences the output.
`timescale 1ns / 1ps
`default_nettype none
module bfcc_ctrl import bfcc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     end_of_line,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [1:0] {S_PARSE, S_EVAL, S_EMIT} state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_PARSE: begin
        cmd.take = in_valid && !in_stall;
        if (cmd.take && end_of_line) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.status == ST_FORWARD) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT;
        end else if (stat.out_free) begin
          cmd.post_status = 1'b1;
          cmd.clear_line  = 1'b1;
          state_next      = S_PARSE;
        end
      end
      S_EMIT: begin
        cmd.emit_run = 1'b1;
        if (stat.emit_done) begin
          cmd.clear_line = 1'b1;
          state_next     = S_PARSE;
        end
      end
      default: begin
        state_next = S_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_PARSE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_PARSE);
    end
  end

endmodule
`default_nettype wire

// ===== design/bfcc_dp.sv =====
// Datapath: line parser, CRC, content memory, chunk packer and output register.
`timescale 1ns / 1ps
`default_nettype none
module bfcc_dp import bfcc_pkg::*; #(
  parameter int CONTENT_LIMIT = CONTENT_LIMIT_DEF,
  parameter int LINE_LIMIT    = LINE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  line_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [63:0] frame_chunk,
  output logic [3:0]  chunk_count,
  output logic        last_result,
  output logic [2:0]  line_status
);

  localparam int FRAME_EXTRA = 7;  // '[' ']' four hex digits and newline
  localparam int CW = $clog2(CONTENT_LIMIT + 2);
  localparam int BW = $clog2(LINE_LIMIT + 1);
  localparam int AW = (CONTENT_LIMIT > 1) ? $clog2(CONTENT_LIMIT) : 1;
  localparam int PW = $clog2(CONTENT_LIMIT + FRAME_EXTRA + 1);

  localparam logic [CW-1:0] CNT_LIMIT  = CW'(CONTENT_LIMIT);
  localparam logic [CW-1:0] CNT_OVER   = CW'(CONTENT_LIMIT + 1);
  localparam logic [BW-1:0] SEEN_LIMIT = BW'(LINE_LIMIT);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef enum logic [1:0] {PH_SEEK, PH_BODY, PH_HEX, PH_DONE} phase_t;

  // Per-line parse state.
  phase_t          phase;
  logic [15:0]     crc;
  logic [CW-1:0]   content_count;
  logic [15:0]     received_crc;
  logic [2:0]      hex_cnt;
  logic            hex_bad;
  logic [BW-1:0]   bytes_seen;
  logic            str_end;

  logic            byte_live;
  logic [4:0]      hv;
  logic            wr_en;

  logic [7:0]      mem [CONTENT_LIMIT];
  logic [7:0]      rd_data;
  logic [AW-1:0]   rd_addr;

  // Emit state.
  logic [PW-1:0]   pos, pos_next, pos_prev;
  logic [PW-1:0]   frame_len, rel;
  logic [63:0]     asm_data;
  logic [3:0]      asm_cnt;
  logic            asm_full;
  logic            asm_last;
  logic            add, xfer, last_byte;
  logic [7:0]      gen_byte;
  logic            out_free;
  status_t         status;

  assign byte_live = cmd.take && !str_end && (bytes_seen < SEEN_LIMIT);
  assign hv        = hex_value(line_byte);
  assign wr_en     = byte_live && (line_byte != CH_NUL) && (phase == PH_BODY) &&
                     (line_byte != CH_CLOSE) && (content_count < CNT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_line) begin
      phase         <= PH_SEEK;
      crc           <= CRC_INIT;
      content_count <= '0;
      received_crc  <= '0;
      hex_cnt       <= '0;
      hex_bad       <= 1'b0;
      bytes_seen    <= '0;
      str_end       <= 1'b0;
    end else if (byte_live) begin
      bytes_seen <= bytes_seen + 1'b1;
      if (line_byte == CH_NUL) begin
        str_end <= 1'b1;
      end else begin
        case (phase)
          PH_SEEK: begin
            if (line_byte == CH_OPEN) begin
              crc   <= crc_feed(CRC_INIT, line_byte);
              phase <= PH_BODY;
            end
          end
          PH_BODY: begin
            crc <= crc_feed(crc, line_byte);
            if (line_byte == CH_CLOSE) begin
              phase <= PH_HEX;
            end else if (content_count < CNT_LIMIT) begin
              content_count <= content_count + 1'b1;
            end else begin
              content_count <= CNT_OVER;
            end
          end
          PH_HEX: begin
            if (!hv[4]) begin
              hex_bad <= 1'b1;
            end else begin
              received_crc <= {received_crc[11:0], hv[3:0]};
            end
            hex_cnt <= hex_cnt + 1'b1;
            if (hex_cnt == 3'd3) begin
              phase <= PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Content memory: one write port for parsing, one registered read port for emitting.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[content_count[AW-1:0]] <= line_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    if (phase == PH_SEEK) begin
      status = ST_NO_START;
    end else if (phase != PH_DONE) begin
      status = ST_NO_END;
    end else if (hex_bad || (received_crc != crc)) begin
      status = ST_CRC_BAD;
    end else if ((content_count == '0) || (content_count > CNT_LIMIT)) begin
      status = ST_BAD_LEN;
    end else begin
      status = ST_FORWARD;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign frame_len = PW'(content_count) + PW'(FRAME_EXTRA);
  assign rel       = pos - PW'(content_count);
  assign last_byte = (pos == frame_len - 1'b1);
  assign add       = cmd.emit_run && !asm_full && (pos != frame_len);
  assign xfer      = asm_full && out_free;

  always_comb begin
    if (cmd.emit_start) begin
      pos_next = '0;
    end else if (add) begin
      pos_next = pos + 1'b1;
    end else begin
      pos_next = pos;
    end
  end

  // The read runs one position ahead so that rd_data always holds the byte for pos.
  assign pos_prev = pos_next - 1'b1;
  assign rd_addr  = pos_prev[AW-1:0];

  always_comb begin
    if (pos == '0) begin
      gen_byte = CH_OPEN;
    end else if (pos <= PW'(content_count)) begin
      gen_byte = rd_data;
    end else begin
      case (rel)
        PW'(1):  gen_byte = CH_CLOSE;
        PW'(2):  gen_byte = hex_char(crc[15:12]);
        PW'(3):  gen_byte = hex_char(crc[11:8]);
        PW'(4):  gen_byte = hex_char(crc[7:4]);
        PW'(5):  gen_byte = hex_char(crc[3:0]);
        default: gen_byte = CH_NL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_full <= 1'b0;
    end else if (cmd.emit_start) begin
      pos      <= '0;
      asm_data <= '0;
      asm_cnt  <= '0;
      asm_full <= 1'b0;
      asm_last <= 1'b0;
    end else begin
      if (xfer) begin
        asm_data <= '0;
        asm_cnt  <= '0;
        asm_full <= 1'b0;
        asm_last <= 1'b0;
      end
      if (add) begin
        asm_data[asm_cnt[2:0]*8 +: 8] <= gen_byte;
        asm_cnt  <= asm_cnt + 1'b1;
        asm_last <= last_byte;
        if (asm_cnt == 4'd7 || last_byte) begin
          asm_full <= 1'b1;
        end
      end
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post_status) begin
      out_valid   <= 1'b1;
      frame_chunk <= '0;
      chunk_count <= '0;
      last_result <= 1'b1;
      line_status <= status;
    end else if (xfer) begin
      out_valid   <= 1'b1;
      frame_chunk <= asm_data;
      chunk_count <= asm_cnt;
      last_result <= asm_last;
      line_status <= ST_FORWARD;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.status    = status;
  assign stat.out_free  = out_free;
  assign stat.emit_done = asm_full && asm_last && out_free;

endmodule
`default_nettype wire

// ===== design/bracket_frame_crc16_checker.sv =====
// Top level of the bracket frame CRC-16 checker.
`timescale 1ns / 1ps
`default_nettype none
// Takes a line one byte per request, finds the first '[' and the first ']' after it, runs
// CRC-16/Modbus over that frame, buffers the content and reads the next four characters as
// a hex CRC. On the byte flagged end_of_line it gives one status request (line_status
// nonzero, chunk_count zero) or, for a good frame, the rebuilt "[content]" plus four
// upper-case CRC digits and a newline, up to eight bytes per request, with last_result on the
// final one. Bytes are taken at one per cycle within a line. After the end byte the input
// stalls while the line is evaluated, and a rejected line posts its status once the output
// register is free; a forwarded line keeps the input stalled while its frame is packed from
// the single read port of the content memory, walked one byte per cycle while no full chunk
// waits to move out; stalls on the output lengthen this.
module bracket_frame_crc16_checker import bfcc_pkg::*; #(
  parameter int CONTENT_LIMIT = CONTENT_LIMIT_DEF,
  parameter int LINE_LIMIT    = LINE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  line_byte,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] frame_chunk,
  output logic [3:0]  chunk_count,
  output logic        last_result,
  output logic [2:0]  line_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfcc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_line (end_of_line),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  bfcc_dp #(
    .CONTENT_LIMIT (CONTENT_LIMIT),
    .LINE_LIMIT    (LINE_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .line_byte   (line_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .frame_chunk (frame_chunk),
    .chunk_count (chunk_count),
    .last_result (last_result),
    .line_status (line_status)
  );

endmodule
`default_nettype wire

// ===== design/bfcc_checker.sv =====
// Port-level checks of the bracket frame CRC checker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_frame_crc16_checker_defines.svh"
module bfcc_checker import bfcc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] frame_chunk,
  input logic [3:0]  chunk_count,
  input logic        last_result,
  input logic [2:0]  line_status
);

  logic        fwd_req;
  logic        rej_req;
  logic        mid_req;
  logic        out_held;
  logic        empty_req;
  logic        fwd_count_ok;
  logic [67:0] out_word;

  assign fwd_req      = out_valid && (line_status == ST_FORWARD);
  assign rej_req      = out_valid && (line_status != ST_FORWARD);
  assign mid_req      = out_valid && !last_result;
  assign out_held     = out_valid && out_stall;
  assign empty_req    = (chunk_count == 4'd0) && (frame_chunk == 64'd0);
  assign fwd_count_ok = (chunk_count != 4'd0) && (chunk_count <= 4'd8);
  assign out_word     = {frame_chunk, chunk_count};

  // Only the final chunk of a forwarded frame may be partly filled.
  `BFCC_ASSERT_NOW(a_mid_chunk_full, mid_req, fwd_req && (chunk_count == 4'd8), "non-final chunk is not full")

  // A rejected line gives a single empty request.
  `BFCC_ASSERT_NOW(a_reject_empty, rej_req, last_result && empty_req, "rejected line request is not empty")

  `BFCC_ASSERT_NOW(a_forward_count, fwd_req, fwd_count_ok, "forwarded chunk has a bad byte count")

  // Input is held off while a frame is still being sent out.
  `BFCC_ASSERT_NOW(a_stall_mid_frame, mid_req, in_stall, "input taken while a frame is partly sent")

  `BFCC_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled output request changed")

endmodule

bind bracket_frame_crc16_checker bfcc_checker u_bfcc_checker (.*);
`default_nettype wire

// ===== tb/bfcc_line_checker.sv =====
// Checker that predicts and compares the chunk requests of the bracket frame CRC-16 checker.
`timescale 1ns / 1ps
module bfcc_line_checker import bfcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  line_byte,
  input  logic        end_of_line,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] frame_chunk,
  input  logic [3:0]  chunk_count,
  input  logic        last_result,
  input  logic [2:0]  line_status,
  input  logic        end_check,
  output int          pending,
  output int          fail_count,
  output int          chunks_seen,
  output int          lines_forwarded
);

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    SEEK_OPEN,
    IN_BODY,
    IN_HEX,
    FRAME_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [63:0] chunk;
    logic [3:0]  count;
    logic        last;
    status_t     status;
  } chunk_t;

  chunk_t       expected_chunks[$];
  parse_phase_t phase;
  logic [15:0]  frame_crc;
  logic [15:0]  sent_crc;
  logic [7:0]   content [CONTENT_LIMIT_DEF];
  int           body_len;
  int           digits;
  int           seen;
  logic         digit_bad;
  logic         nul_hit;
  int           mismatches = 0;

  assign fail_count = mismatches + (end_check ? pending : 0);

  // Reflected CRC-16 with the Modbus polynomial, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    return -1;
  endfunction

  function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
  endfunction

  task automatic clear_line();
    phase     = SEEK_OPEN;
    frame_crc = CRC_INIT;
    sent_crc  = 16'h0000;
    body_len  = 0;
    digits    = 0;
    seen      = 0;
    digit_bad = 1'b0;
    nul_hit   = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int v;
    if (nul_hit || seen >= LINE_LIMIT_DEF) return;
    seen++;
    if (b == 8'h00) begin
      nul_hit = 1'b1;
      return;
    end
    case (phase)
      SEEK_OPEN: begin
        if (b == CH_OPEN) begin
          frame_crc = crc_byte(CRC_INIT, b);
          phase = IN_BODY;
        end
      end
      IN_BODY: begin
        frame_crc = crc_byte(frame_crc, b);
        if (b == CH_CLOSE) begin
          phase = IN_HEX;
        end else if (body_len < CONTENT_LIMIT_DEF) begin
          content[body_len] = b;
          body_len++;
        end else begin
          // Oversized content keeps feeding the CRC; the count just saturates.
          body_len = CONTENT_LIMIT_DEF + 1;
        end
      end
      IN_HEX: begin
        v = hex_digit(b);
        if (v < 0) begin
          digit_bad = 1'b1;
        end else begin
          sent_crc = {sent_crc[11:0], v[3:0]};
        end
        digits++;
        if (digits >= 4) phase = FRAME_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic close_line();
    logic [7:0] frame [CONTENT_LIMIT_DEF + 7];
    int         n;
    int         k;
    chunk_t     c;
    status_t    st;
    if (phase == SEEK_OPEN) st = ST_NO_START;
    else if (phase != FRAME_DONE) st = ST_NO_END;
    else if (digit_bad || sent_crc != frame_crc) st = ST_CRC_BAD;
    else if (body_len == 0 || body_len > CONTENT_LIMIT_DEF) st = ST_BAD_LEN;
    else st = ST_FORWARD;

    if (st != ST_FORWARD) begin
      c.chunk  = '0;
      c.count  = 4'd0;
      c.last   = 1'b1;
      c.status = st;
      expected_chunks.push_back(c);
    end else begin
      frame[0] = CH_OPEN;
      for (k = 0; k < body_len; k++) frame[k + 1] = content[k];
      n = body_len + 1;
      frame[n]     = CH_CLOSE;
      frame[n + 1] = nibble_ascii(frame_crc[15:12]);
      frame[n + 2] = nibble_ascii(frame_crc[11:8]);
      frame[n + 3] = nibble_ascii(frame_crc[7:4]);
      frame[n + 4] = nibble_ascii(frame_crc[3:0]);
      frame[n + 5] = CH_LF;
      n = n + 6;
      for (k = 0; k < n; k += 8) begin
        c.chunk = '0;
        c.count = 4'd0;
        for (int i = 0; i < 8 && k + i < n; i++) begin
          c.chunk[8*i +: 8] = frame[k + i];
          c.count = c.count + 4'd1;
        end
        c.last   = (k + 8 >= n);
        c.status = ST_FORWARD;
        expected_chunks.push_back(c);
      end
      lines_forwarded++;
    end
    clear_line();
  endtask

  always @(posedge clk) begin : watch
    chunk_t want;
    if (rst) begin
      clear_line();
    end else begin
      // Inputs first, so a line closed at this edge is already expected.
      if (in_valid && !in_stall) begin
        parse_byte(line_byte);
        if (end_of_line) close_line();
      end
      if (out_valid && !out_stall) begin
        chunks_seen++;
        if (expected_chunks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR %0t: unexpected request chunk=%h count=%0d last=%0b status=%0d",
                     $time, frame_chunk, chunk_count, last_result, line_status);
          end
        end else begin
          want = expected_chunks.pop_front();
          if (want.chunk !== frame_chunk || want.count !== chunk_count ||
              want.last !== last_result || want.status !== line_status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR %0t: expected chunk=%h count=%0d last=%0b status=%0d", $time,
                       want.chunk, want.count, want.last, want.status);
              $display("              got chunk=%h count=%0d last=%0b status=%0d",
                       frame_chunk, chunk_count, last_result, line_status);
            end
          end
        end
      end
      pending = expected_chunks.size();
    end
  end

endmodule

// ===== tb/tb_bracket_frame_crc16_checker.sv =====
// Testbench top for the bracket frame CRC-16 checker: line stimulus, handshake pacing, verdict.
`timescale 1ns / 1ps
module tb_bracket_frame_crc16_checker;
  import bfcc_pkg::*;

  localparam int         LINE_BYTES = 470;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;

  typedef enum int {
    FR_GOOD,
    FR_WRONG_CRC,
    FR_NOT_HEX
  } frame_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  line_byte = 8'h00;
  logic        end_of_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] frame_chunk;
  logic [3:0]  chunk_count;
  logic        last_result;
  logic [2:0]  line_status;

  logic        end_check = 1'b0;
  int          pending;
  int          fail_count;
  int          chunks_seen;
  int          lines_forwarded;

  logic [7:0]  line_buf[$];
  int          bytes_sent = 0;
  int          lines_sent = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          rx_wait = 0;
  logic        rx_took = 1'b0;

  // Characters just outside the hex ranges, plus CR, LF and space.
  logic [7:0]  not_hex [9] = '{8'h0D, 8'h0A, 8'h20, 8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  bracket_frame_crc16_checker dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .line_byte   (line_byte),
    .end_of_line (end_of_line),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_chunk (frame_chunk),
    .chunk_count (chunk_count),
    .last_result (last_result),
    .line_status (line_status)
  );

  bfcc_line_checker line_chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .line_byte       (line_byte),
    .end_of_line     (end_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_chunk     (frame_chunk),
    .chunk_count     (chunk_count),
    .last_result     (last_result),
    .line_status     (line_status),
    .end_check       (end_check),
    .pending         (pending),
    .fail_count      (fail_count),
    .chunks_seen     (chunks_seen),
    .lines_forwarded (lines_forwarded)
  );

  always #5 clk = ~clk;

  // Output side: after each accepted request, stall for a random number of cycles.
  always @(posedge clk) rx_took <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (rx_took) begin
      rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d requests still expected", pending);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] ascii_hex(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (lower ? 8'h57 : 8'h37) + {4'h0, v};
  endfunction

  task automatic put_junk(input int n, input bit any_byte);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (!any_byte && (b == CH_OPEN || b == 8'h00));
      line_buf.push_back(b);
    end
  endtask

  // Appends '[', content, ']' and four CRC digits of random case; the bad modes flip the CRC or put a non-hex digit.
  task automatic put_frame(input int len, input int fill, input frame_mode_t mode);
    logic [15:0] crc;
    logic [7:0]  b;
    int          flip;
    line_buf.push_back(CH_OPEN);
    crc = crc_feed(CRC_INIT, CH_OPEN);
    repeat (len) begin
      if (fill >= 0) b = fill[7:0];
      else do b = 8'($urandom_range(1, 255)); while (b == CH_CLOSE);
      line_buf.push_back(b);
      crc = crc_feed(crc, b);
    end
    line_buf.push_back(CH_CLOSE);
    crc = crc_feed(crc, CH_CLOSE);
    if (mode == FR_WRONG_CRC) begin
      flip = $urandom_range(1, 15);
      crc = crc ^ (flip[15:0] << (4 * $urandom_range(0, 3)));
    end
    for (int k = 3; k >= 0; k--) begin
      line_buf.push_back(ascii_hex(crc[4*k +: 4], 1'($urandom_range(0, 1))));
    end
    if (mode == FR_NOT_HEX) begin
      line_buf[line_buf.size() - 1 - $urandom_range(0, 3)] = not_hex[$urandom_range(0, 8)];
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    line_byte   <= b;
    end_of_line <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
    lines_sent++;
  endtask

  // The sender goes idle until every expected request has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int kind;
    int cut;
    int pos;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines: empty content, no start, NUL before the bracket, open frame,
    // a 0xFF content byte, and a non-hex CRC character.
    put_frame(0, -1, FR_GOOD);
    send_line();
    line_buf.push_back(8'h5A);
    send_line();
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_OPEN);
    send_line();
    line_buf.push_back(CH_OPEN);
    send_line();
    put_frame(1, 8'hFF, FR_GOOD);
    send_line();
    put_frame(1, 8'h01, FR_NOT_HEX);
    send_line();
    drain();

    while (bytes_sent < LINE_BYTES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (lines_sent == 10) begin
        put_junk($urandom_range(0, 2), 1'b0);
        put_frame(CONTENT_LIMIT_DEF, -1, FR_GOOD);
      end else if (lines_sent == 15) begin
        // Oversized content whose last CRC digit is the final examined byte;
        // the trailing bytes fall past the line limit.
        put_junk(LINE_LIMIT_DEF - CONTENT_LIMIT_DEF - 8, 1'b0);
        put_frame(CONTENT_LIMIT_DEF + 2, -1, FR_GOOD);
        put_junk(3, 1'b1);
      end else begin
        kind = $urandom_range(0, 19);
        if (kind == 16) begin
          put_junk($urandom_range(1, 12), 1'b0);
        end else if (kind == 17) begin
          put_junk($urandom_range(1, 10), 1'b1);
        end else begin
          put_junk($urandom_range(0, 3), 1'b0);
          if (kind == 18) put_frame(0, -1, FR_GOOD);
          else if (kind == 19) put_frame($urandom_range(15, 40), -1, FR_GOOD);
          else if (kind >= 10 && kind <= 11) put_frame($urandom_range(1, 14), -1, FR_WRONG_CRC);
          else if (kind >= 12 && kind <= 13) put_frame($urandom_range(1, 14), -1, FR_NOT_HEX);
          else put_frame($urandom_range(1, 14), -1, FR_GOOD);
          put_junk($urandom_range(0, 3), 1'b1);
          if (kind == 14) begin
            cut = $urandom_range(1, line_buf.size() - 1);
            repeat (cut) line_buf.delete(line_buf.size() - 1);
          end else if (kind == 15) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            line_buf[pos] = 8'h00;
          end
        end
      end
      send_line();
      if (lines_sent % 6 == 5) drain();
    end

    end_of_line <= 1'b0;
    drain();
    repeat (20) @(negedge clk);
    end_check = 1'b1;
    @(negedge clk);
    $display("Sent %0d line bytes in %0d lines; checked %0d result requests, %0d lines forwarded.",
             bytes_sent, lines_sent, chunks_seen, lines_forwarded);
    $display("Lines included missing brackets, bad and short CRCs, NUL cuts, empty, full and "
             , "oversized content, and bytes past the line limit.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bfcc_pkg.sv
design/bfcc_ctrl.sv
design/bfcc_dp.sv
design/bracket_frame_crc16_checker.sv
design/bfcc_checker.sv
tb/bfcc_line_checker.sv
tb/tb_bracket_frame_crc16_checker.sv
